### rtl/olad_pkg.sv
// olad_pkg: shared constants, request/status codes, FSM state type and cell
// broadcast type for the ordered list block; no dependencies
`default_nettype none

package olad_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int REQ_W    = 2;
    localparam int POS_W    = 4;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [REQ_W-1:0] {
        REQ_APPEND = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_READ   = 2'd2,
        REQ_NONE   = 2'd3
    } olad_req_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE      = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_BAD_POS   = 2'd3
    } olad_status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } olad_state_t;

    // command broadcast to every cell of the chain
    typedef struct packed {
        logic                     append;
        logic                     delete_en;
        logic signed [DATA_W-1:0] data;
    } olad_bcast_t;

endpackage

`default_nettype wire

### rtl/olad_cell.sv
// olad_cell: one list slot; compares against the broadcast key, passes the
// match flag down the chain, loads the key on an append at the tail and takes
// its neighbor's entry on a delete; depends on olad_pkg
`default_nettype none

module olad_cell (
    input  wire logic                             aclk,
    input  wire olad_pkg::olad_bcast_t            bcast_i,
    input  wire logic                             in_use_i,
    input  wire logic                             is_tail_i,
    input  wire logic                             hit_i,
    input  wire logic signed [olad_pkg::DATA_W-1:0] next_data_i,
    output logic                                  hit_o,
    output logic signed [olad_pkg::DATA_W-1:0]   data_o
);
    import olad_pkg::*;

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    logic                     match;

    assign match  = in_use_i && (data_reg == bcast_i.data);
    assign hit_o  = hit_i || match;
    assign data_o = data_reg;

    always_comb begin
        data_next = data_reg;
        if (bcast_i.append && is_tail_i) begin
            data_next = bcast_i.data;
        end else if (bcast_i.delete_en && (hit_i || match)) begin
            // at or behind the first match: close the gap
            data_next = next_data_i;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

endmodule

`default_nettype wire

### rtl/ordered_list_append_delete_top.sv
// ordered_list_append_delete_top: insertion-ordered list of signed words
// built as a chain of olad_cell slots; depends on olad_pkg and olad_cell
//
//  channel | direction | ports                                   | handshake
//  --------+-----------+-----------------------------------------+----------
//  request | in        | s_req_type, s_value, s_position         | s_valid/s_ready
//  result  | out       | m_status, m_count, m_read_value         | m_valid/m_ready
//
// sequence: each request is first captured from the transfer, then every
//   cell compares and updates in parallel and the result is loaded; a new
//   request is taken only once the current one completes, and the execute
//   step waits while a previous result still sits unclaimed in the output register
// reset: aresetn (synchronous, active low) empties the list and drops m_valid;
//   the cell entries themselves are not cleared
`default_nettype none

module ordered_list_append_delete_top (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [olad_pkg::REQ_W-1:0]          s_req_type,
    input  wire logic signed [olad_pkg::DATA_W-1:0]  s_value,
    input  wire logic [olad_pkg::POS_W-1:0]          s_position,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [olad_pkg::STATUS_W-1:0]            m_status,
    output logic [olad_pkg::COUNT_W-1:0]             m_count,
    output logic signed [olad_pkg::DATA_W-1:0]       m_read_value
);
    import olad_pkg::*;

    // control state
    olad_state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             m_valid_reg, m_valid_next;

    // captured request
    olad_req_t                req_reg;
    logic signed [DATA_W-1:0] key_reg;
    logic [POS_W-1:0]         pos_reg;

    // result register
    olad_status_t             status_reg, status_next;
    logic signed [DATA_W-1:0] rdata_reg, rdata_next;
    logic [CNT_W-1:0]         rcount_reg;

    logic        exec_fire;
    logic        full;
    logic        found;
    logic        pos_ok;
    olad_bcast_t bcast;

    // cell chain wiring
    logic                     hit_chain [CAPACITY+1];
    logic signed [DATA_W-1:0] cell_data [CAPACITY];

    // ---------------------------------------------------------------
    // state machine: next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (exec_fire) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state machine: outputs
    always_comb begin
        s_ready   = 1'b0;
        exec_fire = 1'b0;
        case (state_reg)
            S_IDLE: s_ready = 1'b1;
            S_EXEC: exec_fire = !m_valid_reg || m_ready;
            default: begin
                s_ready   = 1'b0;
                exec_fire = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // cell chain
    assign hit_chain[0] = 1'b0;

    assign bcast.append    = exec_fire && (req_reg == REQ_APPEND) && !full;
    assign bcast.delete_en = exec_fire && (req_reg == REQ_DELETE);
    assign bcast.data      = key_reg;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic signed [DATA_W-1:0] neighbor;
        if (i == CAPACITY - 1) begin : g_last
            // last slot has no neighbor; its content is dropped by the count
            assign neighbor = cell_data[i];
        end else begin : g_mid
            assign neighbor = cell_data[i+1];
        end

        olad_cell u_cell (
            .aclk        (aclk),
            .bcast_i     (bcast),
            .in_use_i    (CNT_W'(i) < count_reg),
            .is_tail_i   (CNT_W'(i) == count_reg),
            .hit_i       (hit_chain[i]),
            .next_data_i (neighbor),
            .hit_o       (hit_chain[i+1]),
            .data_o      (cell_data[i])
        );
    end

    assign found  = hit_chain[CAPACITY];
    assign full   = (count_reg == CNT_W'(CAPACITY));
    assign pos_ok = (CMP_W'(pos_reg) < CMP_W'(count_reg));

    // ---------------------------------------------------------------
    // result and count update
    always_comb begin
        status_next = STAT_DONE;
        rdata_next  = '0;
        count_next  = count_reg;
        case (req_reg)
            REQ_APPEND: begin
                if (full) begin
                    status_next = STAT_FULL;
                end else begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            REQ_DELETE: begin
                if (found) begin
                    count_next = count_reg - CNT_W'(1);
                end else begin
                    status_next = STAT_NOT_FOUND;
                end
            end
            REQ_READ: begin
                if (pos_ok) begin
                    rdata_next = cell_data[IDX_W'(pos_reg)];
                end else begin
                    status_next = STAT_BAD_POS;
                end
            end
            default: begin
                status_next = STAT_DONE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (exec_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (exec_fire) begin
                count_reg <= count_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= olad_req_t'(s_req_type);
            key_reg <= s_value;
            pos_reg <= s_position;
        end
        if (exec_fire) begin
            status_reg <= status_next;
            rdata_reg  <= rdata_next;
            rcount_reg <= count_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = status_reg;
    assign m_count      = COUNT_W'(rcount_reg);
    assign m_read_value = rdata_reg;

    // ---------------------------------------------------------------
    // assertions
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_append_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (exec_fire && req_reg == REQ_APPEND && !full)
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("accepted append did not grow the list");

    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && status_reg == STAT_FULL) |-> (count_reg == CNT_W'(CAPACITY)))
        else $error("full status reported on a list with room");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && status_reg != STAT_DONE) |-> (rdata_reg == '0))
        else $error("nonzero read data on a failed request");

endmodule

`default_nettype wire
